### hdl/shfr_pkg.sv
// Package for the sync-header frame receiver.
// Holds the header byte constants and the input and result transaction types.
// No dependencies.
`default_nettype none

package shfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'h53;
    localparam logic [7:0] HDR_THIRD  = 8'h41;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } t_rx_item;

    typedef struct packed {
        logic        frame_done;
        logic        checksum_ok;
        logic [7:0]  left_speed;
        logic [7:0]  right_speed;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [31:0] last_good_time;
    } t_result;

endpackage

`default_nettype wire

### hdl/sync_header_frame_receiver.sv
// Sync-header frame receiver: header hunt, four payload bytes, additive checksum.
// Each result is registered in the output register, or in the skid register while
// the output is stalled. Throughput: one byte per cycle while the skid register is
// empty; the two-entry output stage keeps input acceptance while one result waits.
// Reset (synchronous, active low) returns to the header hunt and clears the payload,
// the running sum, the good-frame time and both output entries. Depends on shfr_pkg.
`default_nettype none

module sync_header_frame_receiver (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire shfr_pkg::t_rx_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output shfr_pkg::t_result      o_out_data
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SECOND = 3'd1,
        PH_THIRD  = 3'd2,
        PH_DATA0  = 3'd3,
        PH_DATA1  = 3'd4,
        PH_DATA2  = 3'd5,
        PH_DATA3  = 3'd6,
        PH_CHECK  = 3'd7
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [3:0][7:0]   r_payload, n_payload;
    logic [7:0]        r_sum, n_sum;
    logic [31:0]       r_good_time, n_good_time;
    logic              n_done, n_ok;

    logic              r_out_valid;
    shfr_pkg::t_result r_out;
    logic              r_skid_valid;
    shfr_pkg::t_result r_skid;
    shfr_pkg::t_result n_result;

    logic              in_accept;
    logic              out_free;
    logic [1:0]        data_idx;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign data_idx = 2'(r_phase - PH_DATA0);

    always_comb begin
        n_phase     = r_phase;
        n_payload   = r_payload;
        n_sum       = r_sum;
        n_good_time = r_good_time;
        n_done      = 1'b0;
        n_ok        = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                n_phase = (i_in_data.rx_byte == shfr_pkg::HDR_FIRST) ? PH_SECOND : PH_HUNT;
            end
            PH_SECOND: begin
                n_phase = (i_in_data.rx_byte == shfr_pkg::HDR_SECOND) ? PH_THIRD : PH_HUNT;
            end
            PH_THIRD: begin
                if (i_in_data.rx_byte == shfr_pkg::HDR_THIRD) begin
                    n_phase = PH_DATA0;
                    n_sum   = 8'h00;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CHECK: begin
                n_done = 1'b1;
                if (i_in_data.rx_byte == r_sum) begin
                    n_ok        = 1'b1;
                    n_good_time = i_in_data.now_ms;
                end
                n_phase = PH_HUNT;
            end
            PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3: begin
                n_payload[data_idx] = i_in_data.rx_byte;
                n_sum               = r_sum + i_in_data.rx_byte;
                n_phase             = t_phase'(r_phase + 3'd1);
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        n_result.frame_done     = n_done;
        n_result.checksum_ok    = n_ok;
        n_result.left_speed     = n_payload[0];
        n_result.right_speed    = n_payload[1];
        n_result.left_trigger   = n_payload[2];
        n_result.right_trigger  = n_payload[3];
        n_result.last_good_time = n_good_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_payload    <= '0;
            r_sum        <= 8'h00;
            r_good_time  <= 32'h0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_payload   <= n_payload;
                r_sum       <= n_sum;
                r_good_time <= n_good_time;
            end
            // The skid entry holds a result older than any new input, so it drains first.
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

endmodule

`default_nettype wire

### hdl/shfr_checker.sv
// Port-level checker for the sync-header frame receiver, with its bind statement.
// Depends on shfr_pkg and on the top level sync_header_frame_receiver.
`default_nettype none

module shfr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire shfr_pkg::t_rx_item i_in_data,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire shfr_pkg::t_result o_out_data
);

    // A good checksum can only be reported on the checksum byte of a frame.
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.checksum_ok |-> o_out_data.frame_done)
        else $error("checksum_ok without frame_done");

    // The input only backs up once the output register holds a result.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while output register empty");

    // A stalled input transaction is held by the sender.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input transaction changed or dropped");

    // A stalled result transaction stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // Reset empties both output entries.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output stage not empty after reset");

endmodule

bind sync_header_frame_receiver shfr_checker u_shfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for sync_header_frame_receiver: directed table, then random frames.
// Expected: typed-in rows, else a local predictor of the header hunt, payload and checksum.
// Depends on shfr_pkg and the sync_header_frame_receiver RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_THIRD  = 3'd2;
    localparam logic [2:0] PH_DATA0  = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd7;

    localparam shfr_pkg::t_result RES_IDLE = '0;
    localparam shfr_pkg::t_result RES_FF_GOOD =
        {1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF};
    localparam shfr_pkg::t_result RES_ZERO_BAD = {1'b1, 1'b0, 32'h0, 32'hFFFF_FFFF};

    typedef enum logic [1:0] {
        PACE_A,     // sender idles 38 %, receiver stalls 61 %
        PACE_B,     // sender idles 61 %, receiver stalls 38 %
        PACE_FREE   // no idling on either side
    } t_pace;

    typedef struct packed {
        logic               typed;
        shfr_pkg::t_result  res;
        shfr_pkg::t_rx_item item;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    shfr_pkg::t_rx_item i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    shfr_pkg::t_result  o_out_data;

    // Typed-in expectation that travels with the transaction currently offered.
    logic              typed_valid;
    shfr_pkg::t_result typed_res;

    t_pace             pace = PACE_A;
    logic              hold_req = 1'b0;
    logic              hold_done = 1'b0;
    int                fail_cnt = 0;
    int                rnd_sent = 0;
    int                cycle_cnt = 0;
    shfr_pkg::t_result expected_outputs[$];
    t_dir_row          dir_rows[$];
    shfr_pkg::t_result predicted;

    // Predictor state.
    logic [2:0]  mdl_phase = PH_HUNT;
    logic [7:0]  mdl_payload[4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [7:0]  mdl_sum = 8'h00;
    logic [31:0] mdl_good_time = 32'h0;

    sync_header_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic shfr_pkg::t_result predict_rx_byte(input logic [7:0] b,
                                                          input logic [31:0] now);
        shfr_pkg::t_result r;
        logic [2:0]        slot;
        r = '0;
        case (mdl_phase)
            PH_HUNT: begin
                mdl_phase = (b == shfr_pkg::HDR_FIRST) ? PH_SECOND : PH_HUNT;
            end
            PH_SECOND: begin
                mdl_phase = (b == shfr_pkg::HDR_SECOND) ? PH_THIRD : PH_HUNT;
            end
            PH_THIRD: begin
                if (b == shfr_pkg::HDR_THIRD) begin
                    mdl_phase = PH_DATA0;
                    mdl_sum = 8'h00;
                end else begin
                    mdl_phase = PH_HUNT;
                end
            end
            PH_CHECK: begin
                r.frame_done = 1'b1;
                if (b == mdl_sum) begin
                    r.checksum_ok = 1'b1;
                    mdl_good_time = now;
                end
                mdl_phase = PH_HUNT;
            end
            default: begin
                slot = mdl_phase - PH_DATA0;
                mdl_payload[slot[1:0]] = b;
                mdl_sum = mdl_sum + b;
                mdl_phase = mdl_phase + 3'd1;
            end
        endcase
        r.left_speed     = mdl_payload[0];
        r.right_speed    = mdl_payload[1];
        r.left_trigger   = mdl_payload[2];
        r.right_trigger  = mdl_payload[3];
        r.last_good_time = mdl_good_time;
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predicted = predict_rx_byte(i_in_data.rx_byte, i_in_data.now_ms);
            expected_outputs.push_back(typed_valid ? typed_res : predicted);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outputs.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_cnt++;
            end else begin
                predicted = expected_outputs.pop_front();
                cmp_field("frame_done", 32'(predicted.frame_done),
                          32'(o_out_data.frame_done));
                cmp_field("checksum_ok", 32'(predicted.checksum_ok),
                          32'(o_out_data.checksum_ok));
                cmp_field("left_speed", 32'(predicted.left_speed),
                          32'(o_out_data.left_speed));
                cmp_field("right_speed", 32'(predicted.right_speed),
                          32'(o_out_data.right_speed));
                cmp_field("left_trigger", 32'(predicted.left_trigger),
                          32'(o_out_data.left_trigger));
                cmp_field("right_trigger", 32'(predicted.right_trigger),
                          32'(o_out_data.right_trigger));
                cmp_field("last_good_time", predicted.last_good_time,
                          o_out_data.last_good_time);
            end
        end
    end

    // Receiver side: random stalls per pace, plus one long hold-off on request.
    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end else begin
                case (pace)
                    PACE_A:  i_out_stall <= ($urandom_range(99) < 61);
                    PACE_B:  i_out_stall <= ($urandom_range(99) < 38);
                    default: i_out_stall <= 1'b0;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic add_row(input logic [7:0] b, input logic [31:0] now,
                           input logic typed, input shfr_pkg::t_result res);
        t_dir_row row;
        row.item.rx_byte = b;
        row.item.now_ms  = now;
        row.typed        = typed;
        row.res          = res;
        dir_rows.push_back(row);
    endtask

    // Offers one transaction and returns at the edge where it is taken.
    task automatic send_item(input shfr_pkg::t_rx_item it, input logic typed,
                             input shfr_pkg::t_result res);
        int idle_pct;
        idle_pct = (pace == PACE_A) ? 38 : (pace == PACE_B) ? 61 : 0;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_data   <= it;
        typed_valid <= typed;
        typed_res   <= res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random payload, the rest noise and broken frames.
    task automatic send_random_burst();
        logic [7:0]         seq[$];
        logic [7:0]         sum;
        logic [7:0]         b;
        int                 kind;
        shfr_pkg::t_rx_item it;
        kind = $urandom_range(99);
        sum = 8'h00;
        if (kind < 80 || kind >= 90) begin
            seq.push_back(shfr_pkg::HDR_FIRST);
            seq.push_back(shfr_pkg::HDR_SECOND);
            seq.push_back(shfr_pkg::HDR_THIRD);
            repeat ((kind < 80) ? 4 : $urandom_range(3, 1)) begin
                b = 8'($urandom_range(255));
                seq.push_back(b);
                sum = sum + b;
            end
            if (kind < 80) begin
                if (kind < 15) begin
                    seq.push_back(sum ^ 8'($urandom_range(255, 1)));
                end else begin
                    seq.push_back(sum);
                end
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(4, 1)) seq.push_back(8'($urandom_range(255)));
        end else begin
            b = $urandom_range(1) ? shfr_pkg::HDR_FIRST : 8'($urandom_range(255));
            seq.push_back(shfr_pkg::HDR_FIRST);
            if ($urandom_range(1)) begin
                seq.push_back((b == shfr_pkg::HDR_SECOND) ? shfr_pkg::HDR_FIRST : b);
            end else begin
                seq.push_back(shfr_pkg::HDR_SECOND);
                seq.push_back((b == shfr_pkg::HDR_THIRD) ? shfr_pkg::HDR_FIRST : b);
            end
        end
        foreach (seq[k]) begin
            it.rx_byte = seq[k];
            it.now_ms  = $urandom();
            send_item(it, 1'b0, RES_IDLE);
            rnd_sent++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        typed_valid <= 1'b0;
        typed_res   <= '0;

        add_row(8'h00, 32'h0000_0000, 1'b1, RES_IDLE);
        add_row(8'hFF, 32'hFFFF_FFFF, 1'b1, RES_IDLE);
        // A 0x55 that breaks the header is consumed, so the 0x53 after it is just noise.
        add_row(shfr_pkg::HDR_FIRST, 32'h0000_0001, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_FIRST, 32'h0000_0002, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_SECOND, 32'h0000_0003, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_FIRST, 32'h0000_0004, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_SECOND, 32'h0000_0005, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_FIRST, 32'h0000_0006, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_FIRST, 32'h0000_0007, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_SECOND, 32'h0000_0008, 1'b1, RES_IDLE);
        add_row(shfr_pkg::HDR_THIRD, 32'h0000_0009, 1'b1, RES_IDLE);
        // The partial payload shows up on the outputs byte by byte.
        add_row(8'hFF, 32'hAAAA_AAAA, 1'b0, RES_IDLE);
        add_row(8'hFF, 32'h5555_5555, 1'b0, RES_IDLE);
        add_row(8'hFF, 32'h0000_0000, 1'b0, RES_IDLE);
        add_row(8'hFF, 32'h8000_0000, 1'b0, RES_IDLE);
        add_row(8'hFC, 32'hFFFF_FFFF, 1'b1, RES_FF_GOOD);
        add_row(shfr_pkg::HDR_FIRST, 32'h1234_5678, 1'b0, RES_IDLE);
        add_row(shfr_pkg::HDR_SECOND, 32'h8765_4321, 1'b0, RES_IDLE);
        add_row(shfr_pkg::HDR_THIRD, 32'h0F0F_0F0F, 1'b0, RES_IDLE);
        add_row(8'h00, 32'hF0F0_F0F0, 1'b0, RES_IDLE);
        add_row(8'h00, 32'h0000_0001, 1'b0, RES_IDLE);
        add_row(8'h00, 32'h7FFF_FFFF, 1'b0, RES_IDLE);
        add_row(8'h00, 32'hFFFF_FFFE, 1'b0, RES_IDLE);
        // A bad checksum keeps the payload and the last good time.
        add_row(8'h01, 32'h0000_0000, 1'b1, RES_ZERO_BAD);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

        while (rnd_sent < RANDOM_ITEMS) begin
            if (rnd_sent >= 2 * RANDOM_ITEMS / 3 && pace != PACE_FREE) begin
                pace = PACE_FREE;
                hold_req = 1'b1;
            end else if (rnd_sent >= RANDOM_ITEMS / 3 && pace == PACE_A) begin
                pace = PACE_B;
            end
            send_random_burst();
        end
        i_in_valid <= 1'b0;

        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hdl/shfr_pkg.sv
hdl/sync_header_frame_receiver.sv
hdl/shfr_checker.sv
tb/sv/tb_top.sv
